/* rtl/uttc_pkg.sv */
// Shared types, constants and calendar helper functions for the Unix time to calendar block.
// Depends on nothing; every other file in rtl takes names from this package by scope.
package uttc_pkg;

    // Epochs and offsets.
    localparam logic [31:0]        UNIX_2030   = 32'd1893456000;
    // Rebase from 2030 to 2001 plus one whole 400-year block (146097 days), so the
    // shifted second count never goes negative.
    localparam logic signed [35:0] SHIFT_SECS  = 36'sd13537929600;
    localparam logic signed [35:0] SECS_HOUR_S = 36'sd3600;
    localparam logic [1:0]         DST_ACTIVE  = 2'b01;

    // Time and calendar block lengths.
    localparam logic [34:0] SECS_DAY   = 35'd86400;
    localparam logic [16:0] SECS_HOUR  = 17'd3600;
    localparam logic [11:0] SECS_MIN   = 12'd60;
    localparam logic [17:0] DAYS_400Y  = 18'd146097;
    localparam logic [17:0] DAYS_100Y  = 18'd36524;
    localparam logic [15:0] DAYS_4Y    = 16'd1461;
    localparam logic [10:0] DAYS_1Y    = 11'd365;
    localparam logic [17:0] DAYS_WEEK  = 18'd7;
    localparam logic [11:0] YEAR_LATE  = 12'd2001;
    localparam logic [11:0] YEAR_EARLY = 12'd1601;
    localparam logic [11:0] YEARS_100  = 12'd100;
    localparam logic [11:0] YEARS_4    = 12'd4;
    localparam logic [4:0]  LEAP_CYCLE = 5'd24;

    // Reciprocal multipliers; each is exact over the operand range it sees.
    localparam logic [27:0] DIV675_MAGIC  = 28'd203613265;
    localparam int          DIV675_SHIFT  = 37;
    localparam logic [18:0] DIV7_MAGIC    = 19'd299594;
    localparam int          DIV7_SHIFT    = 21;
    localparam logic [17:0] DIV3600_MAGIC = 18'd149131;
    localparam int          DIV3600_SHIFT = 29;
    localparam logic [15:0] DIV1461_MAGIC = 16'd45934;
    localparam int          DIV1461_SHIFT = 26;
    localparam logic [12:0] DIV60_MAGIC   = 13'd4370;
    localparam int          DIV60_SHIFT   = 18;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ZONE_HOURS = 2'd0,
        REG_DST_MODE   = 2'd1
    } cfg_reg_t;

    // Working record of one transaction as it moves down the pipeline.
    typedef struct packed {
        logic [33:0] tp;       // shifted, zone-adjusted seconds
        logic [17:0] days;     // shifted day count
        logic        kp;       // set when in the later 400-year block
        logic [16:0] secs;     // second of day
        logic [17:0] rem0;     // day within 400-year block
        logic [14:0] dq;       // week count of the day
        logic [2:0]  dow;      // weekday, 0 is Monday
        logic [4:0]  hour;
        logic [1:0]  j;        // century within block
        logic [15:0] rem1;
        logic [11:0] r1;       // second of hour
        logic [4:0]  i;        // four-year group within century
        logic [5:0]  minute;
        logic [10:0] rem2;
        logic [5:0]  second;
        logic [1:0]  h;        // year within four-year group
        logic [8:0]  rem3;     // day of year, from 0
        logic        leap;
        logic [11:0] year;
        logic [17:0] db;       // shifted day count of January 1
        logic [3:0]  mon_idx;  // month, from 0
        logic [8:0]  mstart;   // day of year of the month's first day
        logic [14:0] yq;       // week count of January 1
        logic [4:0]  zone;
        logic [1:0]  dst;
    } item_t;

    // Day of year (from 0) of the first day of a month (from 0).
    function automatic logic [8:0] month_first(input logic [3:0] idx, input logic leap);
        logic [8:0] first;
        logic [8:0] bump;
        bump = {8'd0, leap};
        case (idx)
            4'd0:    first = 9'd0;
            4'd1:    first = 9'd31;
            4'd2:    first = 9'd59 + bump;
            4'd3:    first = 9'd90 + bump;
            4'd4:    first = 9'd120 + bump;
            4'd5:    first = 9'd151 + bump;
            4'd6:    first = 9'd181 + bump;
            4'd7:    first = 9'd212 + bump;
            4'd8:    first = 9'd243 + bump;
            4'd9:    first = 9'd273 + bump;
            4'd10:   first = 9'd304 + bump;
            4'd11:   first = 9'd334 + bump;
            default: first = 9'd0;
        endcase
        return first;
    endfunction

    // Month (from 0) that holds a given day of year (from 0).
    function automatic logic [3:0] month_index(input logic [8:0] doy, input logic leap);
        logic [3:0] idx;
        idx = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (doy >= month_first(4'(m), leap))
            begin
                idx = 4'(m);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/uttc_day_split.sv */
// First three pipeline stages: rebase and zone shift, split into days, then second of day,
// day within the 400-year block and week count. Depends on uttc_pkg.
module uttc_day_split
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [31:0]          unix_seconds,
    input  logic [4:0]           zone,
    input  logic [1:0]           dst,
    output logic                 out_valid,
    output uttc_pkg::item_t      out_item
);

    uttc_pkg::item_t s1_reg, s1_next;
    uttc_pkg::item_t s2_reg, s2_next;
    uttc_pkg::item_t s3_reg, s3_next;
    logic [2:0]      valid_reg, valid_next;

    logic [31:0]        rebased;
    logic [5:0]         zoff;
    logic signed [35:0] t_ext;
    logic signed [35:0] zoff_ext;
    logic signed [35:0] tp_full;
    logic [54:0]        prod675;
    logic [34:0]        day_secs;
    logic [36:0]        prod7;

    // Stage 1: rebase to 2001, add the zone and the daylight saving hour.
    always_comb
    begin
        rebased  = unix_seconds - uttc_pkg::UNIX_2030;
        t_ext    = 36'(signed'(rebased));
        zoff     = {zone[4], zone} + {5'd0, (dst == uttc_pkg::DST_ACTIVE)};
        zoff_ext = 36'(signed'(zoff));
        tp_full  = t_ext + uttc_pkg::SHIFT_SECS + zoff_ext * uttc_pkg::SECS_HOUR_S;
        s1_next      = '0;
        s1_next.tp   = tp_full[33:0];
        s1_next.zone = zone;
        s1_next.dst  = dst;
    end

    // Stage 2: day count; 86400 is 128 times 675, so shift and then multiply.
    always_comb
    begin
        prod675      = 55'(s1_reg.tp[33:7]) * 55'(uttc_pkg::DIV675_MAGIC);
        s2_next      = s1_reg;
        s2_next.days = prod675[uttc_pkg::DIV675_SHIFT +: 18];
    end

    // Stage 3: second of day, day within the block and week count.
    always_comb
    begin
        day_secs     = 35'(s2_reg.days) * uttc_pkg::SECS_DAY;
        prod7        = 37'(s2_reg.days) * 37'(uttc_pkg::DIV7_MAGIC);
        s3_next      = s2_reg;
        s3_next.secs = 17'(35'(s2_reg.tp) - day_secs);
        s3_next.kp   = (s2_reg.days >= uttc_pkg::DAYS_400Y);
        s3_next.rem0 = s3_next.kp ? (s2_reg.days - uttc_pkg::DAYS_400Y) : s2_reg.days;
        s3_next.dq   = prod7[uttc_pkg::DIV7_SHIFT +: 15];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    // Valid bits move with the data.
    assign valid_next = {valid_reg[1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_item  = s3_reg;

endmodule

/* rtl/uttc_calendar.sv */
// Pipeline stages four to nine: hour, minute and second, the century, four-year and
// year split, month lookup and week count of January 1. Depends on uttc_pkg.
module uttc_calendar
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  uttc_pkg::item_t      in_item,
    output logic                 out_valid,
    output uttc_pkg::item_t      out_item
);

    uttc_pkg::item_t s4_reg, s4_next;
    uttc_pkg::item_t s5_reg, s5_next;
    uttc_pkg::item_t s6_reg, s6_next;
    uttc_pkg::item_t s7_reg, s7_next;
    uttc_pkg::item_t s8_reg, s8_next;
    uttc_pkg::item_t s9_reg, s9_next;
    logic [5:0]      valid_reg, valid_next;

    logic [34:0] prod3600;
    logic [31:0] prod1461;
    logic [24:0] prod60;
    logic [36:0] prod7;
    logic [11:0] year_base;

    // Stage 4: hour, century within the block, weekday.
    always_comb
    begin
        prod3600     = 35'(in_item.secs) * 35'(uttc_pkg::DIV3600_MAGIC);
        s4_next      = in_item;
        s4_next.hour = prod3600[uttc_pkg::DIV3600_SHIFT +: 5];
        // The last day of a 400-year block stays in the fourth century.
        if (in_item.rem0 >= 18'(3 * 36524))
        begin
            s4_next.j = 2'd3;
        end
        else if (in_item.rem0 >= 18'(2 * 36524))
        begin
            s4_next.j = 2'd2;
        end
        else if (in_item.rem0 >= uttc_pkg::DAYS_100Y)
        begin
            s4_next.j = 2'd1;
        end
        else
        begin
            s4_next.j = 2'd0;
        end
        s4_next.rem1 = 16'(in_item.rem0 - 18'(s4_next.j) * uttc_pkg::DAYS_100Y);
        s4_next.dow  = 3'(in_item.days - 18'(in_item.dq) * uttc_pkg::DAYS_WEEK);
    end

    // Stage 5: second of hour and four-year group.
    always_comb
    begin
        prod1461   = 32'(s4_reg.rem1) * 32'(uttc_pkg::DIV1461_MAGIC);
        s5_next    = s4_reg;
        s5_next.r1 = 12'(s4_reg.secs - 17'(s4_reg.hour) * uttc_pkg::SECS_HOUR);
        s5_next.i  = prod1461[uttc_pkg::DIV1461_SHIFT +: 5];
    end

    // Stage 6: minute and day within the four-year group.
    always_comb
    begin
        prod60         = 25'(s5_reg.r1) * 25'(uttc_pkg::DIV60_MAGIC);
        s6_next        = s5_reg;
        s6_next.minute = prod60[uttc_pkg::DIV60_SHIFT +: 6];
        s6_next.rem2   = 11'(s5_reg.rem1 - 16'(s5_reg.i) * uttc_pkg::DAYS_4Y);
    end

    // Stage 7: second, year within the group, leap flag and year number.
    always_comb
    begin
        s7_next        = s6_reg;
        s7_next.second = 6'(s6_reg.r1 - 12'(s6_reg.minute) * uttc_pkg::SECS_MIN);
        // December 31 of a leap year stays in the fourth year.
        if (s6_reg.rem2 >= 11'(3 * 365))
        begin
            s7_next.h = 2'd3;
        end
        else if (s6_reg.rem2 >= 11'(2 * 365))
        begin
            s7_next.h = 2'd2;
        end
        else if (s6_reg.rem2 >= uttc_pkg::DAYS_1Y)
        begin
            s7_next.h = 2'd1;
        end
        else
        begin
            s7_next.h = 2'd0;
        end
        s7_next.rem3 = 9'(s6_reg.rem2 - 11'(s7_next.h) * uttc_pkg::DAYS_1Y);
        // Fourth year of a group is leap unless it closes a century other than the fourth.
        s7_next.leap = (s7_next.h == 2'd3)
                       && ((s6_reg.i != uttc_pkg::LEAP_CYCLE) || (s6_reg.j == 2'd3));
        year_base    = s6_reg.kp ? uttc_pkg::YEAR_LATE : uttc_pkg::YEAR_EARLY;
        s7_next.year = year_base + 12'(s6_reg.j) * uttc_pkg::YEARS_100
                       + 12'(s6_reg.i) * uttc_pkg::YEARS_4 + 12'(s7_next.h);
    end

    // Stage 8: month lookup and day count of January 1.
    always_comb
    begin
        s8_next         = s7_reg;
        s8_next.db      = s7_reg.days - 18'(s7_reg.rem3);
        s8_next.mon_idx = uttc_pkg::month_index(s7_reg.rem3, s7_reg.leap);
        s8_next.mstart  = uttc_pkg::month_first(s8_next.mon_idx, s7_reg.leap);
    end

    // Stage 9: week count of January 1.
    always_comb
    begin
        prod7      = 37'(s8_reg.db) * 37'(uttc_pkg::DIV7_MAGIC);
        s9_next    = s8_reg;
        s9_next.yq = prod7[uttc_pkg::DIV7_SHIFT +: 15];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s4_reg <= s4_next;
        s5_reg <= s5_next;
        s6_reg <= s6_next;
        s7_reg <= s7_next;
        s8_reg <= s8_next;
        s9_reg <= s9_next;
    end

    // Valid bits move with the data.
    assign valid_next = {valid_reg[4:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_item  = s9_reg;

endmodule

/* rtl/unix_time_to_calendar.sv */
// Top level of the Unix time to calendar converter: configuration registers, the two
// pipeline sections and the result register. Depends on uttc_pkg, uttc_day_split, uttc_calendar.
//
// Usage:
//   Input: drive unix_seconds and raise start for one cycle per transaction. busy is
//   always low, so a transaction is taken at every rising edge with start high, one per
//   cycle with no gaps needed.
//   Configuration: cfg_we with cfg_index (0 zone_hours, 1 dst_mode) and cfg_wdata writes
//   a register at the edge; other indexes are ignored. Each transaction samples the
//   registers when it is taken, and the values used come back on zone_echo and dst_echo.
//   Output: done is high for one cycle with the date and time fields of one transaction.
//   Pipeline: a transaction passes through ten register stages, set by the reciprocal
//   multiply chain (rebase and zone shift, days, week count, hour and weekday, four-year
//   group, minute, year split, month, week of January 1, final assembly).
//   Throughput: one transaction per clock cycle, sustained.
//   Reset: rst_n low clears all valid bits, sets zone_hours to 0 and dst_mode to -1.
//   Transactions in flight at reset are dropped. The receiver cannot stall, so results
//   are never held back.
module unix_time_to_calendar
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        unix_seconds,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_wdata,
    output logic               done,
    output logic [11:0]        year,
    output logic [3:0]         month,
    output logic [4:0]         day,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second_of_minute,
    output logic [8:0]         day_of_year,
    output logic [2:0]         day_of_week,
    output logic [5:0]         week_of_year,
    output logic signed [4:0]  zone_echo,
    output logic signed [1:0]  dst_echo
);

    logic [4:0]      zone_hours_reg;
    logic [1:0]      dst_mode_reg;
    logic            split_valid;
    uttc_pkg::item_t split_item;
    logic            cal_valid;
    uttc_pkg::item_t cal_item;

    logic        done_reg, done_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [8:0]  doy_reg, doy_next;
    logic [2:0]  dow_reg, dow_next;
    logic [5:0]  week_reg, week_next;
    logic [4:0]  zone_reg, zone_next;
    logic [1:0]  dst_reg, dst_next;

    // The pipeline takes a transaction every cycle.
    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_hours_reg <= 5'd0;
            dst_mode_reg   <= 2'b11;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uttc_pkg::REG_ZONE_HOURS: zone_hours_reg <= cfg_wdata;
                uttc_pkg::REG_DST_MODE:   dst_mode_reg   <= cfg_wdata[1:0];
                default:                  ;
            endcase
        end
    end

    uttc_day_split u_day_split
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .unix_seconds (unix_seconds),
        .zone         (zone_hours_reg),
        .dst          (dst_mode_reg),
        .out_valid    (split_valid),
        .out_item     (split_item)
    );

    uttc_calendar u_calendar
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_item   (split_item),
        .out_valid (cal_valid),
        .out_item  (cal_item)
    );

    // Final stage: turn zero-based counts into the one-based result fields; hour, minute and second stay zero-based.
    always_comb
    begin
        done_next   = cal_valid;
        year_next   = cal_item.year;
        month_next  = cal_item.mon_idx + 4'd1;
        day_next    = 5'(cal_item.rem3 - cal_item.mstart + 9'd1);
        hour_next   = cal_item.hour;
        minute_next = cal_item.minute;
        second_next = cal_item.second;
        doy_next    = cal_item.rem3 + 9'd1;
        dow_next    = cal_item.dow + 3'd1;
        week_next   = 6'(cal_item.dq - cal_item.yq + 15'd1);
        zone_next   = cal_item.zone;
        dst_next    = cal_item.dst;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        doy_reg    <= doy_next;
        dow_reg    <= dow_next;
        week_reg   <= week_next;
        zone_reg   <= zone_next;
        dst_reg    <= dst_next;
    end

    assign done             = done_reg;
    assign year             = year_reg;
    assign month            = month_reg;
    assign day              = day_reg;
    assign hour             = hour_reg;
    assign minute           = minute_reg;
    assign second_of_minute = second_reg;
    assign day_of_year      = doy_reg;
    assign day_of_week      = dow_reg;
    assign week_of_year     = week_reg;
    assign zone_echo        = signed'(zone_reg);
    assign dst_echo         = signed'(dst_reg);

`ifndef SYNTHESIS
    // Every transaction taken produces a result.
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##10 done)
        else $error("transaction taken but no result after ten cycles");

    // No result without a matching transaction taken.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 10))
        else $error("result without a matching transaction");

    // Reciprocal divisions must land every time field in range.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour <= 5'd23) && (minute <= 6'd59) && (second_of_minute <= 6'd59))
        else $error("time of day out of range");

    // Calendar split must land month, day, day of year and weekday in range.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1)
                 && (day_of_year >= 9'd1) && (day_of_year <= 9'd366)
                 && (day_of_week >= 3'd1) && (day_of_week <= 3'd7))
        else $error("date field out of range");
`endif

endmodule

/* dv/unix_time_to_calendar_tb.sv */
// Self-checking testbench for unix_time_to_calendar: converts random and edge-case Unix times
// under many zone and daylight-saving settings and checks every date field.
// Depends on uttc_pkg and the unix_time_to_calendar RTL only.
`timescale 1ns / 100ps

module unix_time_to_calendar_tb;

    // Calendar arithmetic constants used by the expected-date calculation.
    localparam longint REBASE_2001_SECS = 915148800;
    localparam longint MINUTE_SECS      = 60;
    localparam longint HOUR_SECS        = 3600;
    localparam longint DAY_SECS         = 86400;
    localparam longint WEEK_SECS        = 604800;
    localparam longint ERA_DAYS         = 146097;
    localparam longint CENTURY_DAYS     = 36524;
    localparam longint LEAP_GROUP_DAYS  = 1461;
    localparam longint YEAR_DAYS        = 365;
    localparam longint BASE_YEAR        = 2001;

    // Register indexes that the block must ignore.
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    // Earliest time the 32-bit window reaches, just after the wrap around 2030.
    localparam logic [31:0] WRAP_EDGE = 32'd4040939648;

    localparam int PIPE_LATENCY  = 10;
    localparam int DRAIN_CYCLES  = PIPE_LATENCY + 20;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 150;

    // Field extremes, wrap edges, leap days and the ends of 400- and 4-year blocks.
    localparam int DIRECTED_COUNT = 20;
    localparam logic [31:0] DIRECTED_SECS [DIRECTED_COUNT] = '{
        32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, uttc_pkg::UNIX_2030, 32'd4040939647,
        WRAP_EDGE, 32'd946684800, 32'd951782400, 32'd951868799,
        32'd978220800, 32'd978307199, 32'd978307200, 32'd1104537599,
        32'd4007750400, 32'd4007836799, 32'd4007836800, 32'd3000000000
    };

    // One converted date as seen on the result ports.
    typedef struct {
        logic [11:0]       year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic [8:0]        day_of_year;
        logic [2:0]        day_of_week;
        logic [5:0]        week;
        logic signed [4:0] zone;
        logic signed [1:0] dst;
    } cal_t;

    // Scoreboard: mirrors the registers, computes expected dates, checks results in order.
    class calendar_scoreboard;
        logic signed [4:0] zone;
        logic signed [1:0] dst;
        cal_t              pending_dates[$];
        int                errors;
        int                conversions_checked;

        function new();
            zone = 5'sd0;
            dst = -2'sd1;
            errors = 0;
            conversions_checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [4:0] data);
            if (idx == uttc_pkg::REG_ZONE_HOURS)
                zone = data;
            else if (idx == uttc_pkg::REG_DST_MODE)
                dst = data[1:0];
        endfunction

        function void floor_divmod(longint v, longint m, output longint q, output longint r);
            q = v / m;
            r = v % m;
            if (r < 0)
            begin
                r += m;
                q -= 1;
            end
        endfunction

        function int month_length(int mon, int leap);
            case (mon)
                2:             return 28 + leap;
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        endfunction

        // Converts one seconds pattern with the current zone and daylight-saving setting.
        function cal_t civil_date(logic [31:0] secs);
            cal_t        d;
            logic [31:0] rel;
            longint      t, days, sod, era, rem, cent, group, yr_in, day_begin, yr;
            longint      wk_all, wk_rem, wk_jan, discard, dom;
            int          leap, mon, mlen;
            rel = secs - uttc_pkg::UNIX_2030;
            t = longint'($signed(rel)) + REBASE_2001_SECS;
            t += (longint'(zone) + ((dst > 0) ? 1 : 0)) * HOUR_SECS;
            floor_divmod(t, DAY_SECS, days, sod);

            // Split the day count into 400/100/4/1-year blocks; the last day of a
            // century or leap group must stay inside its own year.
            floor_divmod(days, ERA_DAYS, era, rem);
            cent = rem / CENTURY_DAYS;
            if (cent > 3)
                cent = 3;
            rem -= cent * CENTURY_DAYS;
            group = rem / LEAP_GROUP_DAYS;
            rem -= group * LEAP_GROUP_DAYS;
            yr_in = rem / YEAR_DAYS;
            if (yr_in > 3)
                yr_in = 3;
            rem -= yr_in * YEAR_DAYS;
            day_begin = era * ERA_DAYS + cent * CENTURY_DAYS + group * LEAP_GROUP_DAYS
                        + yr_in * YEAR_DAYS;
            yr = BASE_YEAR + era * 400 + cent * 100 + group * 4 + yr_in;
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);

            // Walk the months until the remaining days fit.
            mon = 1;
            dom = rem;
            mlen = month_length(mon, leap);
            while (dom >= mlen)
            begin
                dom -= mlen;
                mon++;
                mlen = month_length(mon, leap);
            end

            // Weeks counted from the Monday 2001-01-01, relative to January 1.
            floor_divmod(t, WEEK_SECS, wk_all, wk_rem);
            floor_divmod(day_begin, 7, wk_jan, discard);

            d.year = 12'(yr);
            d.month = 4'(mon);
            d.day = 5'(dom + 1);
            d.hour = 5'(sod / HOUR_SECS);
            d.minute = 6'((sod % HOUR_SECS) / MINUTE_SECS);
            d.second = 6'(sod % MINUTE_SECS);
            d.day_of_year = 9'(rem + 1);
            d.day_of_week = 3'(wk_rem / DAY_SECS + 1);
            d.week = 6'(wk_all - wk_jan + 1);
            d.zone = zone;
            d.dst = dst;
            return d;
        endfunction

        function void note_timestamp(logic [31:0] secs);
            pending_dates.push_back(civil_date(secs));
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_date(cal_t got);
            cal_t want;
            if (pending_dates.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding, year %0d", $time,
                         got.year);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            conversions_checked++;
            compare("year", want.year, got.year);
            compare("month", want.month, got.month);
            compare("day", want.day, got.day);
            compare("hour", want.hour, got.hour);
            compare("minute", want.minute, got.minute);
            compare("second_of_minute", want.second, got.second);
            compare("day_of_year", want.day_of_year, got.day_of_year);
            compare("day_of_week", want.day_of_week, got.day_of_week);
            compare("week_of_year", want.week, got.week);
            compare("zone_echo", want.zone, got.zone);
            compare("dst_echo", want.dst, got.dst);
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [31:0]       unix_seconds = 32'd0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = 2'd0;
    logic [4:0]        cfg_wdata = 5'd0;
    logic              busy;
    logic              done;
    logic [11:0]       year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second_of_minute;
    logic [8:0]        day_of_year;
    logic [2:0]        day_of_week;
    logic [5:0]        week_of_year;
    logic signed [4:0] zone_echo;
    logic signed [1:0] dst_echo;

    calendar_scoreboard sb = new();
    cal_t               observed;
    int                 cycle_count = 0;

    unix_time_to_calendar DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .unix_seconds     (unix_seconds),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .done             (done),
        .year             (year),
        .month            (month),
        .day              (day),
        .hour             (hour),
        .minute           (minute),
        .second_of_minute (second_of_minute),
        .day_of_year      (day_of_year),
        .day_of_week      (day_of_week),
        .week_of_year     (week_of_year),
        .zone_echo        (zone_echo),
        .dst_echo         (dst_echo)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     sb.pending_dates.size());
            $display("unix_time_to_calendar verification failed");
            $finish;
        end
    end

    // Result monitor: every done cycle carries one transaction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            observed.year = year;
            observed.month = month;
            observed.day = day;
            observed.hour = hour;
            observed.minute = minute;
            observed.second = second_of_minute;
            observed.day_of_year = day_of_year;
            observed.day_of_week = day_of_week;
            observed.week = week_of_year;
            observed.zone = zone_echo;
            observed.dst = dst_echo;
            sb.check_date(observed);
        end
    end

    // Unix seconds of January 1 of a year, negative before 1970.
    function automatic longint jan1_unix(int y);
        longint days;
        days = longint'(y - 1970) * YEAR_DAYS
               + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400)
               - (1969 / 4 - 1969 / 100 + 1969 / 400);
        return days * DAY_SECS;
    endfunction

    // Random seconds: four in ten plain random, the rest near year ends, the wrap edge,
    // end of February and the block ends around 2000 and 2096.
    function automatic logic [31:0] pick_seconds();
        longint base;
        int     y;
        case ($urandom_range(0, 9))
            4, 5, 6:
            begin
                y = $urandom_range(1962, 2097);
                base = jan1_unix(y) - longint'(sb.zone) * HOUR_SECS;
                return 32'(base + $urandom_range(0, 4 * 86400) - 2 * DAY_SECS);
            end
            7:
                return WRAP_EDGE + $urandom_range(0, 400000) - 200000;
            8:
            begin
                y = $urandom_range(1962, 2097);
                return 32'(jan1_unix(y) + $urandom_range(55, 62) * DAY_SECS
                           + $urandom_range(0, 86399));
            end
            9:
            begin
                y = ($urandom_range(0, 1) == 0) ? 2001 : 2097;
                return 32'(jan1_unix(y) + $urandom_range(0, 3 * 86400) - 2 * DAY_SECS);
            end
            default:
                return $urandom();
        endcase
    endfunction

    // Presents one transaction and holds it until the block takes it.
    task automatic send_item(input logic [31:0] secs);
        start <= 1'b1;
        unix_seconds <= secs;
        do
            @(posedge clk);
        while (busy);
        sb.note_timestamp(secs);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [4:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Writes both registers and one ignored index with junk data.
    task automatic set_zone(input logic signed [4:0] zone, input logic signed [1:0] dst,
                            input logic [1:0] spare_idx);
        cfg_write(uttc_pkg::REG_ZONE_HOURS, zone);
        cfg_write(uttc_pkg::REG_DST_MODE, {3'($urandom()), dst});
        cfg_write(spare_idx, 5'($urandom()));
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending_dates.size() != 0)
            @(posedge clk);
    endtask

    // Sends a phase of random transactions in bursts with random gaps, or back to back when no_gaps is set.
    task automatic run_bursts(input int count, input bit no_gaps);
        int sent;
        int burst;
        int gap;
        int r;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                send_item(pick_seconds());
                sent++;
            end
            r = $urandom_range(0, 9);
            gap = (no_gaps || r < 4) ? 0 : (r < 8) ? $urandom_range(1, 6)
                                                   : $urandom_range(7, 14);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;
    endtask

    // Stimulus: directed items at reset settings, then random phases over zone settings.
    initial
    begin
        int phase_zone [8];
        int phase_dst [8];
        logic signed [4:0] zone;
        logic signed [1:0] dst;

        phase_zone = '{-16, 15, -12, 14, 0, 7, -7, 1};
        phase_dst = '{1, 1, 0, -2, -1, 0, 1, -2};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIRECTED_COUNT; n++)
            send_item(DIRECTED_SECS[n]);
        start <= 1'b0;
        wait_idle();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < 8)
            begin
                zone = 5'(phase_zone[p]);
                dst = 2'(phase_dst[p]);
            end
            else
            begin
                zone = 5'($urandom());
                dst = 2'($urandom());
            end
            set_zone(zone, dst, (p % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3);
            run_bursts(PHASE_ITEMS, p % 4 == 3);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_dates.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_dates.size());
            sb.errors++;
        end

        $display("Checked %0d conversions: %0d directed edge cases, then %0d zone/DST settings",
                 sb.conversions_checked, DIRECTED_COUNT, PHASE_COUNT);
        $display("covering zone extremes, the unused DST code and ignored register writes.");
        if (sb.errors == 0)
            $display("unix_time_to_calendar verification clean");
        else
            $display("unix_time_to_calendar verification failed");
        $finish;
    end

endmodule
